>>> rtl/spbw_pkg.sv
// ----------------------------------------------------------------------------
// spbw_pkg
// Shared types, constants and arithmetic helpers of the sheared periodic
// boundary unit.
// ----------------------------------------------------------------------------
package spbw_pkg;

    // word and fixed point format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int BOX_BITS  = 31;

    // register file
    localparam int ADDR_BITS = 5;
    localparam int REG_BITS  = 3;
    localparam logic [REG_BITS-1:0] REG_BOX_X       = 3'd0;
    localparam logic [REG_BITS-1:0] REG_BOX_Y       = 3'd1;
    localparam logic [REG_BITS-1:0] REG_BOX_Z       = 3'd2;
    localparam logic [REG_BITS-1:0] REG_SHEAR_RATE  = 3'd3;
    localparam logic [REG_BITS-1:0] REG_START_SHIFT = 3'd4;

    // command codes
    localparam int CMD_BITS = 3;
    localparam logic [CMD_BITS-1:0] CMD_WRAP     = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRAP_VEL = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_WRAP_DT  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_ADVANCE  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_PECULIAR = 3'd4;

    // two-pass multiplier: a is split into a low unsigned and a high signed part
    localparam int MUL_A_BITS = 50;
    localparam int MUL_B_BITS = 34;
    localparam int MUL_SPLIT  = 24;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    // wide signed sums before clamping
    localparam int SUM_BITS = MUL_P_BITS + 2;
    // shift plus step, and the wrapped x before reduction
    localparam int SH_BITS  = WORD_BITS + 1;
    localparam int DVD_BITS = 2 * WORD_BITS + 1;

    // bit-serial divider
    localparam int DIV_N_BITS     = 2 * WORD_BITS;
    localparam int DIV_SHORT_ITER = WORD_BITS + 2;
    localparam int DIV_LONG_ITER  = DIV_N_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_LONG_ITER + 1);
    localparam int FQ_BITS        = DIV_SHORT_ITER;

    localparam logic signed [SUM_BITS-1:0] W_MAX =
        {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] W_MIN = ~W_MAX;

    typedef enum logic [2:0] {
        M_RATE_LY, M_N_VB, M_DT_VB, M_N_USE, M_Y_RATE
    } t_msel;

    typedef enum logic [1:0] {
        D_Y, D_Z, D_X, D_SUM
    } t_dsel;

    typedef enum logic [3:0] {
        CAP_NONE, CAP_Y, CAP_Z, CAP_X, CAP_SUM, CAP_VB, CAP_NV, CAP_D,
        CAP_USE, CAP_SUMADD, CAP_NU, CAP_PV
    } t_cap;

    typedef struct packed {
        logic  accept;
        logic  mul_go;
        t_msel msel;
        logic  div_go;
        t_dsel dsel;
        t_cap  cap;
        logic  load_out;
    } t_ctrl;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_stat;

    // divide by 2^FRAC_BITS, round half to even
    function automatic logic signed [MUL_P_BITS-1:0] rne_frac(
        input logic signed [MUL_P_BITS-1:0] p);
        logic signed [MUL_P_BITS-1:0] q;
        logic [FRAC_BITS-1:0]         frac;
        logic [FRAC_BITS-1:0]         half;
        logic                         up;
        q    = p >>> FRAC_BITS;
        frac = p[FRAC_BITS-1:0];
        half = {1'b1, {(FRAC_BITS-1){1'b0}}};
        up   = (frac > half) || ((frac == half) && q[0]);
        return q + MUL_P_BITS'(up);
    endfunction

    // out of the signed word range
    function automatic logic over_w(input logic signed [SUM_BITS-1:0] v);
        return (v > W_MAX) || (v < W_MIN);
    endfunction

    // saturate to the signed word range
    function automatic logic [WORD_BITS-1:0] clamp_w(input logic signed [SUM_BITS-1:0] v);
        logic [WORD_BITS-1:0] res;
        if (v > W_MAX) begin
            res = W_MAX[WORD_BITS-1:0];
        end else if (v < W_MIN) begin
            res = W_MIN[WORD_BITS-1:0];
        end else begin
            res = v[WORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/spbw_mul.sv
// ----------------------------------------------------------------------------
// spbw_mul
// Signed multiplier in two passes: low part of a, then high part added in
// at its weight. Result is valid with the done pulse.
// ----------------------------------------------------------------------------
module spbw_mul import spbw_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic signed [MUL_A_BITS-1:0] i_a,
    input  logic signed [MUL_B_BITS-1:0] i_b,
    output logic                         o_done,
    output logic signed [MUL_P_BITS-1:0] o_prod
);

    localparam int HI_BITS   = MUL_A_BITS - MUL_SPLIT;
    localparam int LO_P_BITS = MUL_B_BITS + MUL_SPLIT + 1;
    localparam int HI_P_BITS = MUL_B_BITS + HI_BITS;

    logic                          r_ph;
    logic                          r_done;
    logic signed [MUL_P_BITS-1:0]  r_acc;
    logic signed [MUL_B_BITS-1:0]  r_b;
    logic signed [HI_BITS-1:0]     r_hi;
    logic signed [MUL_SPLIT:0]     w_lo;
    logic signed [LO_P_BITS-1:0]   w_lo_p;
    logic signed [HI_P_BITS-1:0]   w_hi_p;

    // partial products
    assign w_lo   = $signed({1'b0, i_a[MUL_SPLIT-1:0]});
    assign w_lo_p = LO_P_BITS'(i_b) * LO_P_BITS'(w_lo);
    assign w_hi_p = HI_P_BITS'(r_b) * HI_P_BITS'(r_hi);

    // pass control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_ph;
            r_ph   <= i_go;
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_acc <= MUL_P_BITS'(w_lo_p);
            r_b   <= i_b;
            r_hi  <= $signed(i_a[MUL_A_BITS-1:MUL_SPLIT]);
        end else if (r_ph) begin
            r_acc <= r_acc + (MUL_P_BITS'(w_hi_p) <<< MUL_SPLIT);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    // a new product never starts while the high pass is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> !r_ph)
        else $error("multiplier restarted mid product");

endmodule

>>> rtl/spbw_div.sv
// ----------------------------------------------------------------------------
// spbw_div
// Restoring unsigned divider, one quotient bit per cycle. A short run takes
// a dividend of DIV_SHORT_ITER bits, a long run the full DIV_N_BITS.
// ----------------------------------------------------------------------------
module spbw_div import spbw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic                  i_long,
    input  logic [DIV_N_BITS-1:0] i_num,
    input  logic [BOX_BITS-1:0]   i_den,
    output logic                  o_done,
    output logic [DIV_N_BITS-1:0] o_quo,
    output logic [BOX_BITS-1:0]   o_rem
);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DIV_N_BITS-1:0]   r_q;
    logic [BOX_BITS-1:0]     r_rem;
    logic [BOX_BITS-1:0]     r_den;
    logic [BOX_BITS:0]       w_trial;
    logic [BOX_BITS:0]       w_diff;
    logic                    w_fit;

    // one trial subtraction
    assign w_trial = {r_rem, r_q[DIV_N_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = w_trial >= {1'b0, r_den};

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_long ? DIV_CNT_BITS'(DIV_LONG_ITER)
                                 : DIV_CNT_BITS'(DIV_SHORT_ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_long ? i_num
                            : {i_num[DIV_SHORT_ITER-1:0], {(DIV_N_BITS-DIV_SHORT_ITER){1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_N_BITS-2:0], w_fit};
            r_rem <= w_fit ? w_diff[BOX_BITS-1:0] : w_trial[BOX_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

    // a run is never restarted while bits are still being produced
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> !r_busy)
        else $error("divider restarted while busy");

    // a busy divider always has bits left to produce
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with empty count");

endmodule

>>> rtl/spbw_dp.sv
// ----------------------------------------------------------------------------
// spbw_dp
// Datapath: operand and result registers, the stored box shift, the shared
// multiplier and divider, rounding, remainder fixup and saturation.
// ----------------------------------------------------------------------------
module spbw_dp import spbw_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctrl                       i_ctrl,
    output t_stat                       o_stat,
    input  logic signed [WORD_BITS-1:0] i_pos_x,
    input  logic signed [WORD_BITS-1:0] i_pos_y,
    input  logic signed [WORD_BITS-1:0] i_pos_z,
    input  logic signed [WORD_BITS-1:0] i_vel_x,
    input  logic [BOX_BITS-1:0]         i_time_step,
    input  logic [BOX_BITS-1:0]         i_box_x,
    input  logic [BOX_BITS-1:0]         i_box_y,
    input  logic [BOX_BITS-1:0]         i_box_z,
    input  logic signed [WORD_BITS-1:0] i_rate,
    input  logic                        i_shift_wr,
    input  logic signed [WORD_BITS-1:0] i_shift_val,
    output logic signed [WORD_BITS-1:0] o_new_pos_x,
    output logic signed [WORD_BITS-1:0] o_new_pos_y,
    output logic signed [WORD_BITS-1:0] o_new_pos_z,
    output logic signed [WORD_BITS-1:0] o_new_vel_x,
    output logic signed [WORD_BITS-1:0] o_shift_now,
    output logic                        o_saturated
);

    // operands
    logic signed [WORD_BITS-1:0]  r_x, r_y, r_z, r_vx;
    logic [BOX_BITS-1:0]          r_dt;
    // intermediates
    logic signed [FQ_BITS-1:0]    r_n;
    logic signed [MUL_A_BITS-1:0] r_vb;
    logic signed [WORD_BITS-1:0]  r_d;
    logic signed [WORD_BITS-1:0]  r_use;
    logic signed [SH_BITS-1:0]    r_sum;
    logic signed [DVD_BITS-1:0]   r_v;
    logic                         r_neg;
    logic [BOX_BITS-1:0]          r_den;
    // results
    logic signed [WORD_BITS-1:0]  r_ox, r_oy, r_oz, r_ov;
    logic                         r_sat;
    logic signed [WORD_BITS-1:0]  r_shift;

    logic [BOX_BITS-1:0]          w_lx, w_ly, w_lz;
    logic signed [MUL_A_BITS-1:0] w_ma;
    logic signed [MUL_B_BITS-1:0] w_mb;
    logic signed [MUL_P_BITS-1:0] w_prod;
    logic signed [MUL_P_BITS-1:0] w_rne;
    logic                         w_mul_done;
    logic signed [DVD_BITS-1:0]   w_dvd;
    logic                         w_long;
    logic [BOX_BITS-1:0]          w_den;
    logic [DIV_N_BITS-1:0]        w_mag;
    logic                         w_div_done;
    logic [DIV_N_BITS-1:0]        w_quo;
    logic [BOX_BITS-1:0]          w_r0;
    logic                         w_nz;
    logic [BOX_BITS-1:0]          w_fr;
    logic signed [FQ_BITS-1:0]    w_fq;
    logic [WORD_BITS-1:0]         w_twice;
    logic                         w_up;
    logic signed [WORD_BITS-1:0]  w_near;
    logic signed [FQ_BITS-1:0]    w_n;
    logic signed [SUM_BITS-1:0]   w_dif_nv, w_dif_nu, w_dif_pv, w_sh_d, w_d_ext;

    // zero length counts as one lsb
    assign w_lx = (i_box_x == '0) ? BOX_BITS'(1) : i_box_x;
    assign w_ly = (i_box_y == '0) ? BOX_BITS'(1) : i_box_y;
    assign w_lz = (i_box_z == '0) ? BOX_BITS'(1) : i_box_z;

    // multiplier operand select
    always_comb begin
        case (i_ctrl.msel)
            M_RATE_LY: begin
                w_ma = MUL_A_BITS'(i_rate);
                w_mb = $signed(MUL_B_BITS'(w_ly));
            end
            M_N_VB: begin
                w_ma = r_vb;
                w_mb = r_n;
            end
            M_DT_VB: begin
                w_ma = r_vb;
                w_mb = $signed(MUL_B_BITS'(r_dt));
            end
            M_N_USE: begin
                w_ma = MUL_A_BITS'(r_use);
                w_mb = r_n;
            end
            M_Y_RATE: begin
                w_ma = MUL_A_BITS'(i_rate);
                w_mb = MUL_B_BITS'(r_y);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    spbw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_ctrl.mul_go),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // divider dividend and divisor select
    always_comb begin
        case (i_ctrl.dsel)
            D_Y: begin
                w_dvd  = DVD_BITS'(r_y);
                w_den  = w_ly;
                w_long = 1'b0;
            end
            D_Z: begin
                w_dvd  = DVD_BITS'(r_z);
                w_den  = w_lz;
                w_long = 1'b0;
            end
            D_X: begin
                w_dvd  = r_v;
                w_den  = w_lx;
                w_long = 1'b1;
            end
            default: begin
                w_dvd  = DVD_BITS'(r_sum);
                w_den  = w_lx;
                w_long = 1'b0;
            end
        endcase
    end

    assign w_mag = w_dvd[DVD_BITS-1] ? DIV_N_BITS'(-w_dvd) : w_dvd[DIV_N_BITS-1:0];

    spbw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_ctrl.div_go),
        .i_long  (w_long),
        .i_num   (w_mag),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_r0)
    );

    // floor quotient and remainder, then nearest image with ties to even
    assign w_nz    = (w_r0 != '0);
    assign w_fr    = (r_neg && w_nz) ? (r_den - w_r0) : w_r0;
    assign w_fq    = r_neg ? $signed(~w_quo[FQ_BITS-1:0] + FQ_BITS'(!w_nz))
                           : $signed(w_quo[FQ_BITS-1:0]);
    assign w_twice = {w_fr, 1'b0};
    assign w_up    = (w_twice > {1'b0, r_den}) || ((w_twice == {1'b0, r_den}) && w_fq[0]);
    assign w_near  = w_up ? $signed({1'b0, w_fr} - {1'b0, r_den}) : $signed({1'b0, w_fr});
    assign w_n     = w_fq + FQ_BITS'(w_up);

    // rounding and wide differences
    assign w_rne    = rne_frac(w_prod);
    assign w_dif_nv = SUM_BITS'(r_vx) - SUM_BITS'(w_prod);
    assign w_dif_nu = SUM_BITS'(r_x) - SUM_BITS'(w_prod);
    assign w_dif_pv = SUM_BITS'(r_vx) - SUM_BITS'(r_vb);
    assign w_sh_d   = SUM_BITS'(r_shift) + SUM_BITS'(r_d);
    assign w_d_ext  = SUM_BITS'(w_rne);

    // stored box shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else if (i_shift_wr) begin
            r_shift <= i_shift_val;
        end else if (i_ctrl.cap == CAP_SUM) begin
            r_shift <= $signed(WORD_BITS'(w_fr));
        end
    end

    // operand capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_x   <= i_pos_x;
            r_y   <= i_pos_y;
            r_z   <= i_pos_z;
            r_vx  <= i_vel_x;
            r_dt  <= i_time_step;
            r_ox  <= i_pos_x;
            r_oy  <= i_pos_y;
            r_oz  <= i_pos_z;
            r_ov  <= i_vel_x;
            r_sat <= 1'b0;
            r_use <= r_shift;
        end
        if (i_ctrl.div_go) begin
            r_neg <= w_dvd[DVD_BITS-1];
            r_den <= w_den;
        end
        case (i_ctrl.cap)
            CAP_Y: begin
                r_n  <= w_n;
                r_oy <= w_near;
            end
            CAP_Z: r_oz <= w_near;
            CAP_X: r_ox <= w_near;
            CAP_VB: r_vb <= w_rne[MUL_A_BITS-1:0];
            CAP_NV: begin
                r_ov  <= clamp_w(w_dif_nv);
                r_sat <= r_sat | over_w(w_dif_nv);
            end
            CAP_D: begin
                r_d   <= clamp_w(w_d_ext);
                r_sat <= r_sat | over_w(w_d_ext);
            end
            CAP_USE: begin
                r_use <= clamp_w(w_sh_d);
                r_sat <= r_sat | over_w(w_sh_d);
            end
            CAP_SUMADD: r_sum <= w_sh_d[SH_BITS-1:0];
            CAP_NU: r_v <= w_dif_nu[DVD_BITS-1:0];
            CAP_PV: begin
                r_ov  <= clamp_w(w_dif_pv);
                r_sat <= r_sat | over_w(w_dif_pv);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            o_new_pos_x <= r_ox;
            o_new_pos_y <= r_oy;
            o_new_pos_z <= r_oz;
            o_new_vel_x <= r_ov;
            o_shift_now <= r_shift;
            o_saturated <= r_sat;
        end
    end

    assign o_stat.mul_done = w_mul_done;
    assign o_stat.div_done = w_div_done;

endmodule

>>> rtl/spbw_ctrl.sv
// ----------------------------------------------------------------------------
// spbw_ctrl
// Command sequencer: walks each command through the multiplier and divider
// steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module spbw_ctrl import spbw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_BITS-1:0] i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_ctrl               o_ctrl,
    input  t_stat               i_stat
);

    typedef enum logic [22:0] {
        S_IDLE   = 23'd1 << 0,
        S_DIVY   = 23'd1 << 1,
        S_WDIVY  = 23'd1 << 2,
        S_DIVZ   = 23'd1 << 3,
        S_WDIVZ  = 23'd1 << 4,
        S_VB     = 23'd1 << 5,
        S_WVB    = 23'd1 << 6,
        S_NV     = 23'd1 << 7,
        S_WNV    = 23'd1 << 8,
        S_DSTEP  = 23'd1 << 9,
        S_WD     = 23'd1 << 10,
        S_USE    = 23'd1 << 11,
        S_SUMADD = 23'd1 << 12,
        S_NU     = 23'd1 << 13,
        S_WNU    = 23'd1 << 14,
        S_DIVX   = 23'd1 << 15,
        S_WDIVX  = 23'd1 << 16,
        S_DIVS   = 23'd1 << 17,
        S_WDIVS  = 23'd1 << 18,
        S_PV     = 23'd1 << 19,
        S_WPV    = 23'd1 << 20,
        S_PVSUB  = 23'd1 << 21,
        S_DONE   = 23'd1 << 22
    } t_state;

    t_state              r_state, n_state;
    logic [CMD_BITS-1:0] r_cmd;
    logic                r_out_valid;
    logic                w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and step commands
    always_comb begin
        n_state         = r_state;
        o_ctrl.accept   = 1'b0;
        o_ctrl.mul_go   = 1'b0;
        o_ctrl.msel     = M_RATE_LY;
        o_ctrl.div_go   = 1'b0;
        o_ctrl.dsel     = D_Y;
        o_ctrl.cap      = CAP_NONE;
        o_ctrl.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.accept = 1'b1;
                    unique case (i_cmd) inside
                        CMD_WRAP, CMD_WRAP_VEL, CMD_WRAP_DT: n_state = S_DIVY;
                        CMD_ADVANCE:  n_state = S_VB;
                        CMD_PECULIAR: n_state = S_PV;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_DIVY: begin
                o_ctrl.div_go = 1'b1;
                o_ctrl.dsel   = D_Y;
                n_state       = S_WDIVY;
            end
            S_WDIVY: begin
                if (i_stat.div_done) begin
                    o_ctrl.cap = CAP_Y;
                    n_state    = S_DIVZ;
                end
            end
            S_DIVZ: begin
                o_ctrl.div_go = 1'b1;
                o_ctrl.dsel   = D_Z;
                n_state       = S_WDIVZ;
            end
            S_WDIVZ: begin
                if (i_stat.div_done) begin
                    o_ctrl.cap = CAP_Z;
                    n_state    = (r_cmd == CMD_WRAP) ? S_NU : S_VB;
                end
            end
            S_VB: begin
                o_ctrl.mul_go = 1'b1;
                o_ctrl.msel   = M_RATE_LY;
                n_state       = S_WVB;
            end
            S_WVB: begin
                if (i_stat.mul_done) begin
                    o_ctrl.cap = CAP_VB;
                    n_state    = (r_cmd == CMD_WRAP_VEL) ? S_NV : S_DSTEP;
                end
            end
            S_NV: begin
                o_ctrl.mul_go = 1'b1;
                o_ctrl.msel   = M_N_VB;
                n_state       = S_WNV;
            end
            S_WNV: begin
                if (i_stat.mul_done) begin
                    o_ctrl.cap = CAP_NV;
                    n_state    = S_NU;
                end
            end
            S_DSTEP: begin
                o_ctrl.mul_go = 1'b1;
                o_ctrl.msel   = M_DT_VB;
                n_state       = S_WD;
            end
            S_WD: begin
                if (i_stat.mul_done) begin
                    o_ctrl.cap = CAP_D;
                    n_state    = (r_cmd == CMD_WRAP_DT) ? S_USE : S_SUMADD;
                end
            end
            S_USE: begin
                o_ctrl.cap = CAP_USE;
                n_state    = S_NU;
            end
            S_SUMADD: begin
                o_ctrl.cap = CAP_SUMADD;
                n_state    = S_DIVS;
            end
            S_NU: begin
                o_ctrl.mul_go = 1'b1;
                o_ctrl.msel   = M_N_USE;
                n_state       = S_WNU;
            end
            S_WNU: begin
                if (i_stat.mul_done) begin
                    o_ctrl.cap = CAP_NU;
                    n_state    = S_DIVX;
                end
            end
            S_DIVX: begin
                o_ctrl.div_go = 1'b1;
                o_ctrl.dsel   = D_X;
                n_state       = S_WDIVX;
            end
            S_WDIVX: begin
                if (i_stat.div_done) begin
                    o_ctrl.cap = CAP_X;
                    n_state    = S_DONE;
                end
            end
            S_DIVS: begin
                o_ctrl.div_go = 1'b1;
                o_ctrl.dsel   = D_SUM;
                n_state       = S_WDIVS;
            end
            S_WDIVS: begin
                if (i_stat.div_done) begin
                    o_ctrl.cap = CAP_SUM;
                    n_state    = S_DONE;
                end
            end
            S_PV: begin
                o_ctrl.mul_go = 1'b1;
                o_ctrl.msel   = M_Y_RATE;
                n_state       = S_WPV;
            end
            S_WPV: begin
                if (i_stat.mul_done) begin
                    o_ctrl.cap = CAP_VB;
                    n_state    = S_PVSUB;
                end
            end
            S_PVSUB: begin
                o_ctrl.cap = CAP_PV;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, command and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= CMD_WRAP;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctrl.accept) begin
                r_cmd <= i_cmd;
            end
            if (o_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // a finished beat is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");

    // a load always raises output valid on the next edge
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load_out |=> r_out_valid)
        else $error("loaded result not presented");

    // the two arithmetic units are never launched together
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.mul_go && o_ctrl.div_go))
        else $error("multiplier and divider launched together");

endmodule

>>> rtl/sheared_periodic_boundary_wrap.sv
// ----------------------------------------------------------------------------
// sheared_periodic_boundary_wrap
// Sheared periodic boundary unit in signed Q15.16: wraps positions into the
// primary cell with the running box x-shift, corrects velocities and
// advances the shift. Holds the configuration registers.
//
//   port group   handshake                  payload
//   in           i_in_valid / o_in_ready    i_cmd, i_pos_x/y/z, i_vel_x, i_time_step
//   out          o_out_valid / i_out_ready  o_new_pos_x/y/z, o_new_vel_x,
//                                           o_shift_now, o_saturated
//   cfg          psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One item at a time; input is ready again once the result of the item has been
// loaded into the output register. Wrap commands run the bit-serial divider
// (34 steps for y, z and the shift fold, 64 for x); advance runs it only for
// the shift fold, and peculiar velocity and unknown codes do not use it.
// Synchronous active-low reset clears the control state and the box shift.
// A waiting result stalls only the finish of the next item.
// ----------------------------------------------------------------------------
module sheared_periodic_boundary_wrap import spbw_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_BITS-1:0]        paddr,
    input  logic [WORD_BITS-1:0]        pwdata,
    output logic [WORD_BITS-1:0]        prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [CMD_BITS-1:0]         i_cmd,
    input  logic signed [WORD_BITS-1:0] i_pos_x,
    input  logic signed [WORD_BITS-1:0] i_pos_y,
    input  logic signed [WORD_BITS-1:0] i_pos_z,
    input  logic signed [WORD_BITS-1:0] i_vel_x,
    input  logic [BOX_BITS-1:0]         i_time_step,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [WORD_BITS-1:0] o_new_pos_x,
    output logic signed [WORD_BITS-1:0] o_new_pos_y,
    output logic signed [WORD_BITS-1:0] o_new_pos_z,
    output logic signed [WORD_BITS-1:0] o_new_vel_x,
    output logic signed [WORD_BITS-1:0] o_shift_now,
    output logic                        o_saturated
);

    logic [BOX_BITS-1:0]         r_box_x, r_box_y, r_box_z;
    logic signed [WORD_BITS-1:0] r_rate, r_start;
    logic                        w_wr;
    logic [REG_BITS-1:0]         w_idx;
    logic                        w_shift_wr;
    t_ctrl                       w_ctrl;
    t_stat                       w_stat;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_BITS-1:2];
    assign pready = 1'b1;
    assign w_shift_wr = w_wr && (w_idx == REG_START_SHIFT);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x <= BOX_BITS'(1 << FRAC_BITS);
            r_box_y <= BOX_BITS'(1 << FRAC_BITS);
            r_box_z <= BOX_BITS'(1 << FRAC_BITS);
            r_rate  <= WORD_BITS'(1 << FRAC_BITS);
            r_start <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BOX_X:       r_box_x <= pwdata[BOX_BITS-1:0];
                REG_BOX_Y:       r_box_y <= pwdata[BOX_BITS-1:0];
                REG_BOX_Z:       r_box_z <= pwdata[BOX_BITS-1:0];
                REG_SHEAR_RATE:  r_rate  <= pwdata;
                REG_START_SHIFT: r_start <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            REG_BOX_X:       prdata = WORD_BITS'(r_box_x);
            REG_BOX_Y:       prdata = WORD_BITS'(r_box_y);
            REG_BOX_Z:       prdata = WORD_BITS'(r_box_z);
            REG_SHEAR_RATE:  prdata = r_rate;
            REG_START_SHIFT: prdata = r_start;
            default:         prdata = '0;
        endcase
    end

    spbw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctrl      (w_ctrl),
        .i_stat      (w_stat)
    );

    spbw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_vel_x     (i_vel_x),
        .i_time_step (i_time_step),
        .i_box_x     (r_box_x),
        .i_box_y     (r_box_y),
        .i_box_z     (r_box_z),
        .i_rate      (r_rate),
        .i_shift_wr  (w_shift_wr),
        .i_shift_val ($signed(pwdata)),
        .o_new_pos_x (o_new_pos_x),
        .o_new_pos_y (o_new_pos_y),
        .o_new_pos_z (o_new_pos_z),
        .o_new_vel_x (o_new_vel_x),
        .o_shift_now (o_shift_now),
        .o_saturated (o_saturated)
    );

endmodule

>>> tb/sv/sheared_periodic_boundary_wrap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sheared_periodic_boundary_wrap_tb
// Self-checking bench for the sheared periodic boundary unit. A predictor in
// 64-bit arithmetic computes each result beat from the accepted input beat;
// the monitor compares field by field. Phases rewrite the box lengths, rate
// and start shift over the APB port between idle points.
// ----------------------------------------------------------------------------
module sheared_periodic_boundary_wrap_tb;
    import spbw_pkg::*;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [WORD_BITS-1:0] px, py, pz, vx;
        logic [BOX_BITS-1:0]  dt;
    } t_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] px, py, pz, vx, sh;
        logic                 sat;
    } t_res;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint PLIM = 64'sd1 <<< 62;
    localparam longint FONE = 64'sd1 <<< FRAC_BITS;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_BITS-1:0] paddr;
    logic [WORD_BITS-1:0] pwdata, prdata;
    logic i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    logic [CMD_BITS-1:0] i_cmd;
    logic signed [WORD_BITS-1:0] i_pos_x, i_pos_y, i_pos_z, i_vel_x;
    logic [BOX_BITS-1:0] i_time_step;
    logic signed [WORD_BITS-1:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic signed [WORD_BITS-1:0] o_new_vel_x, o_shift_now;
    logic o_saturated;

    sheared_periodic_boundary_wrap DUT (.*);

    // predictor copy of configuration and shift
    longint len_x, len_y, len_z, rate, shift_st;
    bit     sat_f;

    t_item  pending_items[$];
    t_res   expected_res[$];
    int     fail_count;
    longint cycle_count;
    int     hold_off;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint floor_q(longint a, longint b, output longint r);
        longint q;
        q = a / b;
        r = a % b;
        if (r < 0) begin
            r += b;
            q -= 1;
        end
        return q;
    endfunction

    function automatic longint round_q(longint a, longint b);
        longint r, q;
        q = floor_q(a, b, r);
        if (r > b - r || (r == b - r && q[0])) q += 1;
        return q;
    endfunction

    function automatic longint nearest_rem(longint v, longint l);
        return v - round_q(v, l) * l;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > WMAX) begin
            sat_f = 1;
            return WMAX;
        end
        if (v < WMIN) begin
            sat_f = 1;
            return WMIN;
        end
        return v;
    endfunction

    // product limited to 2^62 in magnitude; big gives the sign of an overflow
    function automatic longint mul_capped(longint a, longint b, output int big);
        longint ua, ub;
        bit neg;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        neg = (a < 0) != (b < 0);
        big = 0;
        if (ua != 0 && ub > PLIM / ua) begin
            big = neg ? -1 : 1;
            return 0;
        end
        return neg ? -(ua * ub) : ua * ub;
    endfunction

    function automatic longint box_speed();
        return round_q(rate * len_y, FONE);
    endfunction

    function automatic longint shift_delta(longint dt);
        int big;
        longint p;
        p = mul_capped(dt, box_speed(), big);
        if (big != 0) begin
            sat_f = 1;
            return big > 0 ? WMAX : WMIN;
        end
        return sat_word(round_q(p, FONE));
    endfunction

    function automatic t_res predict_wrap(t_item it);
        t_res   res;
        longint x, y, z, v, n, s, p, r;
        int     big;
        x = longint'($signed(it.px));
        y = longint'($signed(it.py));
        z = longint'($signed(it.pz));
        v = longint'($signed(it.vx));
        sat_f = 0;
        if (it.cmd == CMD_WRAP || it.cmd == CMD_WRAP_VEL || it.cmd == CMD_WRAP_DT) begin
            n = round_q(y, len_y);
            s = shift_st;
            if (it.cmd == CMD_WRAP_VEL) begin
                p = mul_capped(n, box_speed(), big);
                if (big != 0) begin
                    sat_f = 1;
                    v = big > 0 ? WMIN : WMAX;
                end else begin
                    v = sat_word(v - p);
                end
            end else if (it.cmd == CMD_WRAP_DT) begin
                s = shift_delta(longint'(it.dt));
                s = sat_word(shift_st + s);
            end
            x = sat_word(nearest_rem(x - n * s, len_x));
            y = sat_word(nearest_rem(y, len_y));
            z = sat_word(nearest_rem(z, len_z));
        end else if (it.cmd == CMD_ADVANCE) begin
            s = shift_st + shift_delta(longint'(it.dt));
            void'(floor_q(s, len_x, r));
            shift_st = sat_word(r);
        end else if (it.cmd == CMD_PECULIAR) begin
            v = sat_word(v - round_q(y * rate, FONE));
        end
        res.px = x[31:0];
        res.py = y[31:0];
        res.pz = z[31:0];
        res.vx = v[31:0];
        res.sh = shift_st[31:0];
        res.sat = sat_f;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    // driver
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            in_gap <= 0;
        end else if (i_in_valid && !o_in_ready) begin
        end else begin
            if (i_in_valid) expected_res.push_back(predict_wrap(pending_items.pop_front()));
            if (in_gap > 0 || (i_in_valid && $urandom_range(0, 3) == 0)) begin
                i_in_valid <= 0;
                in_gap <= (in_gap > 0) ? in_gap - 1 : $urandom_range(0, 14);
            end else if (pending_items.size() > 0) begin
                t_item nx;
                nx = pending_items[0];
                i_in_valid <= 1;
                i_cmd <= nx.cmd;
                i_pos_x <= nx.px;
                i_pos_y <= nx.py;
                i_pos_z <= nx.pz;
                i_vel_x <= nx.vx;
                i_time_step <= nx.dt;
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // monitor and receiver stalls
    int out_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
            out_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                t_res w;
                if (expected_res.size() == 0) begin
                    $display("result beat with no expectation");
                    fail_count++;
                end else begin
                    w = expected_res.pop_front();
                    if (o_new_pos_x !== w.px) report_mismatch("new_pos_x", o_new_pos_x, w.px);
                    if (o_new_pos_y !== w.py) report_mismatch("new_pos_y", o_new_pos_y, w.py);
                    if (o_new_pos_z !== w.pz) report_mismatch("new_pos_z", o_new_pos_z, w.pz);
                    if (o_new_vel_x !== w.vx) report_mismatch("new_vel_x", o_new_vel_x, w.vx);
                    if (o_shift_now !== w.sh) report_mismatch("shift_now", o_shift_now, w.sh);
                    if (o_saturated !== w.sat)
                        report_mismatch("saturated", 32'(o_saturated), 32'(w.sat));
                end
            end
            if (hold_off > 0) begin
                i_out_ready <= 0;
            end else if (out_gap > 0) begin
                i_out_ready <= 0;
                out_gap <= out_gap - 1;
            end else if (o_out_valid && i_out_ready) begin
                out_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
                i_out_ready <= 1;
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic apb_write(logic [REG_BITS-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_BITS'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_BOX_X: len_x = val[30:0] == 0 ? 1 : longint'(val[30:0]);
            REG_BOX_Y: len_y = val[30:0] == 0 ? 1 : longint'(val[30:0]);
            REG_BOX_Z: len_z = val[30:0] == 0 ? 1 : longint'(val[30:0]);
            REG_SHEAR_RATE: rate = longint'($signed(val));
            default: shift_st = longint'($signed(val));
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_res.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.cmd = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        it.px = any_word();
        it.pz = any_word();
        it.vx = any_word();
        it.py = ($urandom_range(0, 2) == 0) ? any_word()
                : 32'($signed(($urandom % 9) - 4) * int'(len_y) + int'($urandom % 65536));
        it.dt = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 8192));
        return it;
    endfunction

    task automatic push(logic [2:0] c, logic [31:0] x, y, z, v, logic [30:0] d);
        t_item it;
        it = '{c, x, y, z, v, d};
        pending_items.push_back(it);
    endtask

    initial begin
        logic [31:0] cfg[5];
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        i_in_valid = 0;
        i_out_ready = 0;
        i_cmd = 0;
        i_pos_x = 0;
        i_pos_y = 0;
        i_pos_z = 0;
        i_vel_x = 0;
        i_time_step = 0;
        fail_count = 0;
        cycle_count = 0;
        hold_off = 0;
        len_x = 65536;
        len_y = 65536;
        len_z = 65536;
        rate = 65536;
        shift_st = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: every command, field extremes, unknown codes, zero dt
        push(CMD_WRAP, 32'h00018000, 32'h00028000, 32'hfffe8000, 0, 0);
        push(CMD_WRAP_VEL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
        push(CMD_WRAP_DT, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
             31'h7fffffff);
        push(CMD_ADVANCE, 0, 0, 0, 0, 31'h7fffffff);
        push(CMD_ADVANCE, 0, 0, 0, 0, 31'h00008000);
        push(CMD_PECULIAR, 0, 32'h80000000, 0, 32'h7fffffff, 0);
        push(CMD_PECULIAR, 0, 32'h7fffffff, 0, 32'h80000000, 0);
        push(3'd5, 32'h1234, 32'h5678, 32'h9abc, 32'hdef0, 31'h1);
        push(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff);
        push(CMD_WRAP, 32'h00008000, 32'h00008000, 32'hffff8000, 0, 0);
        push(CMD_WRAP_VEL, 32'h0, 32'h00018000, 32'h0, 32'h10000, 0);
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: cfg = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff};
                1: cfg = '{32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000};
                2: cfg = '{32'h1, 32'h1, 32'h1, 32'h0, 32'h0};
                default: cfg = '{$urandom_range(1, 32'h00400000), $urandom_range(1, 32'h00400000),
                                 $urandom_range(1, 32'h00400000), $urandom, $urandom};
            endcase
            for (int r = 0; r < 5; r++) apb_write(REG_BITS'(r), cfg[r]);
            for (int k = 0; k < 160; k++) pending_items.push_back(rand_item());
            if (ph == 3) hold_off = 3000;
            wait_idle();
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
